// ----- rtl/core/gct_pkg.sv -----
// Shared types and constants for the glyph cache table.
// Has no dependencies; every other file of the block but gct_glyph_ram imports it.
package gct_pkg;

  // Default sizes of the font set and the glyph table.
  localparam int unsigned GLYPH_SLOTS_DEF = 256;
  localparam int unsigned FONT_SLOTS_DEF  = 8;

  // Field widths fixed by the request and result formats.
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DATA_W = 16;
  // Hash dividend: glyph key plus the font slot index.
  localparam int unsigned HASH_W = 17;

  // Request codes.
  localparam logic [1:0] REQ_FONT_SEL = 2'd0;
  localparam logic [1:0] REQ_STORE    = 2'd1;
  localparam logic [1:0] REQ_LOOKUP   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_GLYPH_LIMIT = 1'b0;
  localparam logic CFG_FONT_LIMIT  = 1'b1;

  // Update commands for the font set; at most one is raised per cycle.
  typedef struct packed {
    logic touch;   // make the addressed font the most recent
    logic insert;  // write a new font into the addressed free slot
    logic evict;   // drop the addressed font
  } font_cmd_t;

endpackage

// ----- rtl/core/glyph_cache_table.sv -----
// Glyph cache table top level: request sequencer, configuration and result register.
// Depends on gct_pkg, gct_glyph_ram, gct_hash_div and gct_font_set.

// One request is worked on at a time; a new transaction is taken while the
// previous result waits in the output register. A font select miss that finds
// the font set full evicts fonts, and each eviction sweeps the glyph table
// once through the single memory read port. A glyph store or lookup first
// runs the 17-step hash remainder and then probes the table one entry at a
// time, up to glyph_limit entries for a lookup miss; a store that must make
// room adds the eviction sweeps. After reset and after every glyph_limit
// write the table is cleared in a pass over all GLYPH_SLOTS entries, during
// which no request is taken.
module glyph_cache_table
  import gct_pkg::*;
#(
  parameter int unsigned GLYPH_SLOTS = GLYPH_SLOTS_DEF,
  parameter int unsigned FONT_SLOTS  = FONT_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [8:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [KEY_W-1:0]         font_id_i,
  input  logic signed [COEF_W-1:0] mat_a_i,
  input  logic signed [COEF_W-1:0] mat_b_i,
  input  logic signed [COEF_W-1:0] mat_c_i,
  input  logic signed [COEF_W-1:0] mat_d_i,
  input  logic [KEY_W-1:0]         glyph_key_i,
  input  logic signed [DATA_W-1:0] advance_x_i,
  input  logic signed [DATA_W-1:0] advance_y_i,
  input  logic [DATA_W-1:0]        bitmap_handle_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [2:0]               font_slot_o,
  output logic [7:0]               glyph_slot_o,
  output logic signed [DATA_W-1:0] found_advance_x_o,
  output logic signed [DATA_W-1:0] found_advance_y_o,
  output logic [DATA_W-1:0]        found_handle_o,
  output logic [8:0]               glyph_total_o,
  output logic [3:0]               font_total_o
);

  localparam int unsigned AW  = $clog2(GLYPH_SLOTS);
  localparam int unsigned LW  = $clog2(GLYPH_SLOTS + 1);
  localparam int unsigned FW  = $clog2(FONT_SLOTS);
  localparam int unsigned FLW = $clog2(FONT_SLOTS + 1);
  // Table word: used flag, owner font, key, advance x, advance y, bitmap.
  localparam int unsigned DW  = 1 + FW + KEY_W + 3 * DATA_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FS, S_FS_CHK, S_ST_CHK, S_EV_SEL, S_EV_FLUSH,
    S_HASH_GO, S_HASH, S_PROBE, S_DONE
  } state_e;

  state_e state_q, ret_q;

  logic [LW-1:0]        glim_q, gcount_q, iss_q, chk_q;
  logic [FLW-1:0]       flim_q;
  logic                 cur_vld_q;
  logic [FW-1:0]        cur_q, victim_q;
  logic [AW-1:0]        clr_q, ra_q, rsp_addr_q, ra_next;
  logic                 rd_vld_q;
  logic [1:0]           type_q;
  logic [KEY_W-1:0]     fid_q, key_q;
  logic [COEF_W-1:0]    ca_q, cb_q, cc_q, cd_q;
  logic [DATA_W-1:0]    ax_q, ay_q, bm_q;
  logic [1:0]           res_status_q;
  logic [AW-1:0]        res_gslot_q;
  logic [DATA_W-1:0]    res_fx_q, res_fy_q, res_fh_q;
  logic                 out_vld_q;
  logic [1:0]           out_status_q;
  logic [2:0]           out_fslot_q;
  logic [7:0]           out_gslot_q;
  logic [DATA_W-1:0]    out_fx_q, out_fy_q, out_fh_q;
  logic [8:0]           out_gtotal_q;
  logic [3:0]           out_ftotal_q;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa;
  logic [DW-1:0]        mem_wd, rd_data;
  logic                 rd_used;
  logic [FW-1:0]        rd_owner;
  logic [KEY_W-1:0]     rd_key;
  logic                 probe_hit, flush_hit, chk_last, can_issue;

  font_cmd_t            fcmd;
  logic [FW-1:0]        fslot, hit_slot, free_slot, victim;
  logic                 font_hit, any_valid;
  logic [FLW-1:0]       fcount;

  logic                 hash_start, hash_done;
  logic [AW-1:0]        hash_rem;

  logic [8:0]           glim_sat;
  logic [3:0]           flim_sat;

  gct_glyph_ram #(.DEPTH(GLYPH_SLOTS), .AW(AW), .DW(DW)) u_ram (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (ra_q),
    .rd_o  (rd_data)
  );

  gct_hash_div #(.LW(LW), .AW(AW)) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_start),
    .dividend_i (HASH_W'(key_q) + HASH_W'(cur_q)),
    .divisor_i  (glim_q),
    .done_o     (hash_done),
    .rem_o      (hash_rem)
  );

  gct_font_set #(.FONT_SLOTS(FONT_SLOTS), .FW(FW), .FLW(FLW)) u_fonts (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fcmd),
    .slot_i      (fslot),
    .font_id_i   (fid_q),
    .coef_a_i    (ca_q),
    .coef_b_i    (cb_q),
    .coef_c_i    (cc_q),
    .coef_d_i    (cd_q),
    .hit_o       (font_hit),
    .hit_slot_o  (hit_slot),
    .free_slot_o (free_slot),
    .victim_o    (victim),
    .any_valid_o (any_valid),
    .count_o     (fcount)
  );

  // Fields of the table word returned by the last read.
  assign rd_used  = rd_data[DW-1];
  assign rd_owner = rd_data[DW-2 -: FW];
  assign rd_key   = rd_data[3*DATA_W +: KEY_W];

  // Probe and sweep bookkeeping.
  assign probe_hit = rd_vld_q && ((type_q == REQ_STORE) ? !rd_used :
                     (rd_used && rd_owner == cur_q && rd_key == key_q));
  assign flush_hit = rd_vld_q && rd_used && rd_owner == victim_q;
  assign chk_last  = rd_vld_q && (chk_q + 1'b1 == glim_q);
  assign can_issue = iss_q < glim_q;
  assign ra_next   = (LW'(ra_q) + 1'b1 >= glim_q) ? '0 : ra_q + 1'b1;

  // Saturated configuration values.
  always_comb begin
    if (cfg_data_i == '0) begin
      glim_sat = 9'd1;
    end else if (32'(cfg_data_i) > 32'(GLYPH_SLOTS)) begin
      glim_sat = 9'(GLYPH_SLOTS);
    end else begin
      glim_sat = cfg_data_i;
    end
    if (cfg_data_i[3:0] == '0) begin
      flim_sat = 4'd1;
    end else if (32'(cfg_data_i[3:0]) > 32'(FONT_SLOTS)) begin
      flim_sat = 4'(FONT_SLOTS);
    end else begin
      flim_sat = cfg_data_i[3:0];
    end
  end

  // Memory port, font set command and hash start for the current state.
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = rsp_addr_q;
    mem_wd     = {1'b0, rd_data[DW-2:0]};
    fcmd       = '0;
    fslot      = victim;
    hash_start = 1'b0;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      S_FS: begin
        fcmd.touch = font_hit;
        fslot      = hit_slot;
      end
      S_FS_CHK: begin
        fcmd.insert = !(fcount >= flim_q && any_valid);
        fslot       = free_slot;
      end
      S_EV_SEL: begin
        fcmd.evict = 1'b1;
      end
      S_EV_FLUSH: begin
        mem_we = flush_hit;
        mem_re = !chk_last && can_issue;
      end
      S_HASH_GO: begin
        hash_start = 1'b1;
      end
      S_PROBE: begin
        mem_we = probe_hit && type_q == REQ_STORE;
        mem_wd = {1'b1, cur_q, key_q, ax_q, ay_q, bm_q};
        mem_re = !probe_hit && !chk_last && can_issue;
      end
      default: begin
      end
    endcase
  end

  // Request sequencer, configuration registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      ret_q     <= S_IDLE;
      clr_q     <= '0;
      glim_q    <= LW'(GLYPH_SLOTS);
      flim_q    <= FLW'(FONT_SLOTS);
      gcount_q  <= '0;
      cur_vld_q <= 1'b0;
      cur_q     <= '0;
      victim_q  <= '0;
      rd_vld_q  <= 1'b0;
      iss_q     <= '0;
      chk_q     <= '0;
      ra_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // A new result in S_DONE refills the register in the same cycle.
      if (out_vld_q && out_ready_i && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(GLYPH_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            type_q       <= req_type_i;
            fid_q        <= font_id_i;
            ca_q         <= mat_a_i;
            cb_q         <= mat_b_i;
            cc_q         <= mat_c_i;
            cd_q         <= mat_d_i;
            key_q        <= glyph_key_i;
            ax_q         <= advance_x_i;
            ay_q         <= advance_y_i;
            bm_q         <= bitmap_handle_i;
            res_status_q <= STAT_NONE;
            res_gslot_q  <= '0;
            res_fx_q     <= '0;
            res_fy_q     <= '0;
            res_fh_q     <= '0;
            unique case (req_type_i)
              REQ_FONT_SEL: state_q <= S_FS;
              REQ_STORE:    state_q <= S_ST_CHK;
              REQ_LOOKUP: begin
                if (cur_vld_q) begin
                  res_status_q <= STAT_MISS;
                  state_q      <= S_HASH_GO;
                end else begin
                  state_q <= S_DONE;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_FS: begin
          if (font_hit) begin
            cur_q        <= hit_slot;
            cur_vld_q    <= 1'b1;
            res_status_q <= STAT_HIT;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_FS_CHK;
          end
        end
        S_FS_CHK: begin
          if (fcount >= flim_q && any_valid) begin
            ret_q   <= S_FS_CHK;
            state_q <= S_EV_SEL;
          end else begin
            cur_q        <= free_slot;
            cur_vld_q    <= 1'b1;
            res_status_q <= STAT_MISS;
            state_q      <= S_DONE;
          end
        end
        S_ST_CHK: begin
          if (!cur_vld_q) begin
            state_q <= S_DONE;
          end else if (gcount_q >= glim_q) begin
            if (any_valid) begin
              ret_q   <= S_ST_CHK;
              state_q <= S_EV_SEL;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_HASH_GO;
          end
        end
        S_EV_SEL: begin
          victim_q <= victim;
          if (cur_vld_q && cur_q == victim) begin
            cur_vld_q <= 1'b0;
          end
          iss_q    <= '0;
          chk_q    <= '0;
          ra_q     <= '0;
          rd_vld_q <= 1'b0;
          state_q  <= S_EV_FLUSH;
        end
        S_EV_FLUSH: begin
          rd_vld_q   <= mem_re;
          rsp_addr_q <= ra_q;
          if (mem_re) begin
            ra_q  <= ra_next;
            iss_q <= iss_q + 1'b1;
          end
          if (rd_vld_q) begin
            chk_q <= chk_q + 1'b1;
          end
          if (flush_hit && gcount_q != '0) begin
            gcount_q <= gcount_q - 1'b1;
          end
          if (chk_last) begin
            state_q <= ret_q;
          end
        end
        S_HASH_GO: begin
          state_q <= S_HASH;
        end
        S_HASH: begin
          if (hash_done) begin
            ra_q     <= hash_rem;
            iss_q    <= '0;
            chk_q    <= '0;
            rd_vld_q <= 1'b0;
            state_q  <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_vld_q   <= mem_re;
          rsp_addr_q <= ra_q;
          if (mem_re) begin
            ra_q  <= ra_next;
            iss_q <= iss_q + 1'b1;
          end
          if (rd_vld_q) begin
            chk_q <= chk_q + 1'b1;
          end
          if (probe_hit) begin
            res_status_q <= STAT_HIT;
            res_gslot_q  <= rsp_addr_q;
            if (type_q == REQ_STORE) begin
              gcount_q <= gcount_q + 1'b1;
            end else begin
              res_fx_q <= rd_data[2*DATA_W +: DATA_W];
              res_fy_q <= rd_data[DATA_W +: DATA_W];
              res_fh_q <= rd_data[DATA_W-1:0];
            end
            state_q <= S_DONE;
          end else if (chk_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_fslot_q  <= cur_vld_q ? 3'(cur_q) : 3'd0;
            out_gslot_q  <= 8'(res_gslot_q);
            out_fx_q     <= res_fx_q;
            out_fy_q     <= res_fy_q;
            out_fh_q     <= res_fh_q;
            out_gtotal_q <= 9'(gcount_q);
            out_ftotal_q <= 4'(fcount);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Configuration writes must arrive only while the block is idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_GLYPH_LIMIT) begin
          glim_q   <= LW'(glim_sat);
          gcount_q <= '0;
          clr_q    <= '0;
          state_q  <= S_CLR;
        end else begin
          flim_q <= FLW'(flim_sat);
        end
      end
    end
  end

  assign in_ready_o        = state_q == S_IDLE;
  assign out_valid_o       = out_vld_q;
  assign status_o          = out_status_q;
  assign font_slot_o       = out_fslot_q;
  assign glyph_slot_o      = out_gslot_q;
  assign found_advance_x_o = out_fx_q;
  assign found_advance_y_o = out_fy_q;
  assign found_handle_o    = out_fh_q;
  assign glyph_total_o     = out_gtotal_q;
  assign font_total_o      = out_ftotal_q;

endmodule

// ----- rtl/core/gct_glyph_ram.sv -----
// Glyph table storage: one write port and one read port with registered data.
// Depends on nothing; sized by its parameters.
module gct_glyph_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 68
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wa_i,
  input  logic [DW-1:0] wd_i,
  input  logic          re_i,
  input  logic [AW-1:0] ra_i,
  output logic [DW-1:0] rd_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ----- rtl/core/gct_hash_div.sv -----
// Restoring remainder unit for the glyph hash: one quotient bit per cycle.
// Depends on gct_pkg for the dividend width.
module gct_hash_div
  import gct_pkg::*;
#(
  parameter int unsigned LW = 9,
  parameter int unsigned AW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HASH_W-1:0] dividend_i,
  input  logic [LW-1:0]     divisor_i,
  output logic              done_o,
  output logic [AW-1:0]     rem_o
);

  localparam int unsigned CW = $clog2(HASH_W);

  logic [LW:0]       rem_q, rem_d, shifted;
  logic [HASH_W-1:0] dvd_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q, done_q;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    shifted = {rem_q[LW-1:0], dvd_q[HASH_W-1]};
    if (shifted >= {1'b0, divisor_i}) begin
      rem_d = shifted - {1'b0, divisor_i};
    end else begin
      rem_d = shifted;
    end
  end

  // Step counter and partial remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
    end else begin
      // Pulse once, after the last step.
      done_q <= !start_i && run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(HASH_W - 1);
        rem_q <= '0;
        dvd_q <= dividend_i;
      end else if (run_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // The remainder is below the table limit, so it fits the address width.
  assign done_o = done_q;
  assign rem_o  = AW'(rem_q);

endmodule

// ----- rtl/core/gct_font_set.sv -----
// Recency-ordered font set: identities, coefficients, ages and valid flags.
// Depends on gct_pkg for field widths and the update command type.
module gct_font_set
  import gct_pkg::*;
#(
  parameter int unsigned FONT_SLOTS = FONT_SLOTS_DEF,
  parameter int unsigned FW         = $clog2(FONT_SLOTS),
  parameter int unsigned FLW        = $clog2(FONT_SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  font_cmd_t         cmd_i,
  input  logic [FW-1:0]     slot_i,
  input  logic [KEY_W-1:0]  font_id_i,
  input  logic [COEF_W-1:0] coef_a_i,
  input  logic [COEF_W-1:0] coef_b_i,
  input  logic [COEF_W-1:0] coef_c_i,
  input  logic [COEF_W-1:0] coef_d_i,
  output logic              hit_o,
  output logic [FW-1:0]     hit_slot_o,
  output logic [FW-1:0]     free_slot_o,
  output logic [FW-1:0]     victim_o,
  output logic              any_valid_o,
  output logic [FLW-1:0]    count_o
);

  logic [FONT_SLOTS-1:0] valid_q, valid_d;
  logic [FW-1:0]         age_q [FONT_SLOTS];
  logic [FW-1:0]         age_d [FONT_SLOTS];
  logic [FLW-1:0]        count_q, count_d;
  logic [KEY_W-1:0]      ident_q [FONT_SLOTS];
  logic [COEF_W-1:0]     ca_q [FONT_SLOTS];
  logic [COEF_W-1:0]     cb_q [FONT_SLOTS];
  logic [COEF_W-1:0]     cc_q [FONT_SLOTS];
  logic [COEF_W-1:0]     cd_q [FONT_SLOTS];

  // Parallel match against every held font; the lowest matching slot wins.
  always_comb begin
    hit_o      = 1'b0;
    hit_slot_o = '0;
    for (int s = FONT_SLOTS - 1; s >= 0; s--) begin
      if (valid_q[s] && ident_q[s] == font_id_i && ca_q[s] == coef_a_i &&
          cb_q[s] == coef_b_i && cc_q[s] == coef_c_i && cd_q[s] == coef_d_i) begin
        hit_o      = 1'b1;
        hit_slot_o = FW'(s);
      end
    end
  end

  // Lowest free slot, and the oldest valid font with ties going to the higher slot.
  always_comb begin
    logic          found;
    logic [FW-1:0] best;
    found       = 1'b0;
    best        = '0;
    victim_o    = '0;
    free_slot_o = '0;
    for (int s = FONT_SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_slot_o = FW'(s);
      end
    end
    for (int s = 0; s < FONT_SLOTS; s++) begin
      if (valid_q[s] && (!found || age_q[s] >= best)) begin
        found    = 1'b1;
        best     = age_q[s];
        victim_o = FW'(s);
      end
    end
    any_valid_o = found;
  end

  // Recency and occupancy updates.
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    count_d = count_q;
    if (cmd_i.touch) begin
      for (int s = 0; s < FONT_SLOTS; s++) begin
        if (valid_q[s] && age_q[s] < age_q[slot_i]) begin
          age_d[s] = age_q[s] + 1'b1;
        end
      end
      age_d[slot_i] = '0;
    end else if (cmd_i.insert) begin
      for (int s = 0; s < FONT_SLOTS; s++) begin
        if (valid_q[s]) begin
          age_d[s] = age_q[s] + 1'b1;
        end
      end
      valid_d[slot_i] = 1'b1;
      age_d[slot_i]   = '0;
      count_d         = count_q + 1'b1;
    end else if (cmd_i.evict) begin
      valid_d[slot_i] = 1'b0;
      age_d[slot_i]   = '0;
      if (count_q != '0) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  // Control state of the set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int s = 0; s < FONT_SLOTS; s++) begin
        age_q[s] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      count_q <= count_d;
    end
  end

  // Font keys are written on insert only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      ident_q[slot_i] <= font_id_i;
      ca_q[slot_i]    <= coef_a_i;
      cb_q[slot_i]    <= coef_b_i;
      cc_q[slot_i]    <= coef_c_i;
      cd_q[slot_i]    <= coef_d_i;
    end
  end

  assign count_o = count_q;

endmodule

// ----- rtl/core/gct_checker.sv -----
// Port-level checks for the glyph cache table, bound to the top level.
// Depends on gct_pkg for status codes and field widths.
module gct_checker
  import gct_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               status_o,
  input logic [2:0]               font_slot_o,
  input logic [8:0]               glyph_total_o,
  input logic [3:0]               font_total_o,
  input logic [DATA_W-1:0]        found_handle_o
);

  // Only one request is in progress: a transaction closes the input side.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a request is in progress");

  // A waiting result holds its payload.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) &&
    $stable(found_handle_o) && $stable(glyph_total_o)))
    else $error("result changed while stalled");

  // A hit or a stored glyph always has a held font behind it.
  a_hit_has_font: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_HIT) |-> font_total_o != 4'd0)
    else $error("hit reported with no font held");

  // Glyphs never outlive the fonts that own them.
  a_glyphs_need_fonts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && font_total_o == 4'd0) |-> glyph_total_o == 9'd0)
    else $error("glyphs held with no font");

endmodule

bind glyph_cache_table gct_checker u_gct_checker (.*);

// ----- tb/glyph_cache_table_tb.sv -----
// Self-checking testbench for the glyph cache table: directed and random requests with
// a built-in predictor of the font set and the probed glyph table.
// Depends on gct_pkg and the glyph_cache_table RTL.
module glyph_cache_table_tb
  import gct_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFONT = 8;
  localparam int NGLYPH = 256;
  localparam int NO_FONT = NFONT;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int POOL_N = 10;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] fid;
    logic [31:0] ca, cb, cc, cd;
    logic [15:0] key, ax, ay, bh;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  fslot;
    logic [7:0]  gslot;
    logic [15:0] fx, fy, fh;
    logic [8:0]  gtot;
    logic [3:0]  ftot;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] req_type_i = '0;
  logic [15:0] font_id_i = '0;
  logic signed [31:0] mat_a_i = '0, mat_b_i = '0, mat_c_i = '0, mat_d_i = '0;
  logic [15:0] glyph_key_i = '0;
  logic signed [15:0] advance_x_i = '0, advance_y_i = '0;
  logic [15:0] bitmap_handle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [2:0] font_slot_o;
  logic [7:0] glyph_slot_o;
  logic signed [15:0] found_advance_x_o, found_advance_y_o;
  logic [15:0] found_handle_o;
  logic [8:0] glyph_total_o;
  logic [3:0] font_total_o;

  glyph_cache_table dut (.*);

  always #5 clk_i = ~clk_i;

  // Mirror of the block state.
  bit          fv[NFONT];
  logic [15:0] fident[NFONT];
  logic [31:0] fa[NFONT], fb[NFONT], fc[NFONT], fd[NFONT];
  int          fage[NFONT];
  int          fcount, cur_font, glim, flim;
  bit          gused[NGLYPH];
  int          gowner[NGLYPH];
  logic [15:0] gkey[NGLYPH], gax[NGLYPH], gay[NGLYPH], gbh[NGLYPH];
  int          gcount;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  request_t cur_req;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int errors = 0;
  bit stall_arm = 0, stall_done = 0;
  int stall_left = 0;

  // Font pool so that selects hit often.
  logic [15:0] pool_id[POOL_N];
  logic [31:0] pool_a[POOL_N], pool_b[POOL_N], pool_c[POOL_N], pool_d[POOL_N];

  function automatic void clear_table();
    for (int i = 0; i < NGLYPH; i++) gused[i] = 0;
    gcount = 0;
  endfunction

  // Drop the least recent font and every glyph it owns.
  function automatic int evict_lru();
    int victim, best;
    victim = NO_FONT;
    best = 0;
    for (int s = 0; s < NFONT; s++)
      if (fv[s] && (victim == NO_FONT || fage[s] >= best)) begin
        victim = s;
        best = fage[s];
      end
    if (victim == NO_FONT) return NO_FONT;
    for (int i = 0; i < glim; i++)
      if (gused[i] && gowner[i] == victim) begin
        gused[i] = 0;
        if (gcount > 0) gcount--;
      end
    fv[victim] = 0;
    fage[victim] = 0;
    if (fcount > 0) fcount--;
    if (cur_font == victim) cur_font = NO_FONT;
    return victim;
  endfunction

  function automatic void apply_config(logic idx, logic [8:0] val);
    int v;
    if (idx == CFG_GLYPH_LIMIT) begin
      v = int'(val);
      glim = (v < 1) ? 1 : (v > NGLYPH) ? NGLYPH : v;
      clear_table();
    end else begin
      v = int'(val[3:0]);
      flim = (v < 1) ? 1 : (v > NFONT) ? NFONT : v;
    end
  endfunction

  // Compute the answer to one accepted request and update the mirror.
  function automatic answer_t cache_answer(request_t r);
    answer_t a;
    int hit, slot, age, idx, v;
    bit dropped;
    a = '0;
    a.status = STAT_NONE;
    if (r.req == REQ_FONT_SEL) begin
      hit = NO_FONT;
      for (int s = 0; s < NFONT; s++)
        if (fv[s] && fident[s] == r.fid && fa[s] == r.ca && fb[s] == r.cb &&
            fc[s] == r.cc && fd[s] == r.cd) begin
          hit = s;
          break;
        end
      if (hit != NO_FONT) begin
        age = fage[hit];
        for (int s = 0; s < NFONT; s++)
          if (fv[s] && fage[s] < age) fage[s]++;
        fage[hit] = 0;
        cur_font = hit;
        a.status = STAT_HIT;
      end else begin
        slot = NO_FONT;
        while (fcount >= flim && evict_lru() != NO_FONT) begin end
        for (int s = 0; s < NFONT; s++)
          if (!fv[s]) begin
            slot = s;
            break;
          end
        if (slot == NO_FONT) slot = evict_lru();
        if (slot < NFONT) begin
          for (int s = 0; s < NFONT; s++)
            if (fv[s]) fage[s]++;
          fv[slot] = 1;
          fident[slot] = r.fid;
          fa[slot] = r.ca;
          fb[slot] = r.cb;
          fc[slot] = r.cc;
          fd[slot] = r.cd;
          fage[slot] = 0;
          fcount++;
          cur_font = slot;
          a.status = STAT_MISS;
        end
      end
    end else if (r.req == REQ_STORE && cur_font < NFONT) begin
      dropped = 0;
      while (gcount >= glim) begin
        v = evict_lru();
        if (v == NO_FONT || cur_font == NO_FONT) begin
          dropped = 1;
          break;
        end
      end
      if (!dropped && cur_font < NFONT) begin
        idx = (int'(r.key) + cur_font) % glim;
        for (int n = 0; n < glim; n++) begin
          if (!gused[idx]) begin
            gused[idx] = 1;
            gowner[idx] = cur_font;
            gkey[idx] = r.key;
            gax[idx] = r.ax;
            gay[idx] = r.ay;
            gbh[idx] = r.bh;
            gcount++;
            a.status = STAT_HIT;
            a.gslot = idx[7:0];
            break;
          end
          if (++idx >= glim) idx = 0;
        end
      end
    end else if (r.req == REQ_LOOKUP && cur_font < NFONT) begin
      a.status = STAT_MISS;
      idx = (int'(r.key) + cur_font) % glim;
      for (int n = 0; n < glim; n++) begin
        if (gused[idx] && gowner[idx] == cur_font && gkey[idx] == r.key) begin
          a.status = STAT_HIT;
          a.gslot = idx[7:0];
          a.fx = gax[idx];
          a.fy = gay[idx];
          a.fh = gbh[idx];
          break;
        end
        if (++idx >= glim) idx = 0;
      end
    end
    a.fslot = (cur_font < NFONT) ? cur_font[2:0] : 3'd0;
    a.gtot = gcount[8:0];
    a.ftot = fcount[3:0];
    return a;
  endfunction

  // Driver: records the accepted transaction, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_answers.push_back(cache_answer(cur_req));
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= cur_req.req;
          font_id_i <= cur_req.fid;
          mat_a_i <= cur_req.ca;
          mat_b_i <= cur_req.cb;
          mat_c_i <= cur_req.cc;
          mat_d_i <= cur_req.cd;
          glyph_key_i <= cur_req.key;
          advance_x_i <= cur_req.ax;
          advance_y_i <= cur_req.ay;
          bitmap_handle_i <= cur_req.bh;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (stall_arm && !stall_done) begin
      stall_left <= 3000;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver ready.
  always @(posedge clk_i)
    out_ready_i <= rst_ni && stall_left == 0 && $urandom_range(99) >= recv_idle_pct;

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, font_slot_o, glyph_slot_o, found_advance_x_o, found_advance_y_o,
             found_handle_o, glyph_total_o, font_total_o};
      if (expected_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status || got.fslot !== want.fslot ||
            got.gslot !== want.gslot || got.fx !== want.fx || got.fy !== want.fy ||
            got.fh !== want.fh || got.gtot !== want.gtot || got.ftot !== want.ftot) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st=%0d fs=%0d gs=%0d ax=%h ay=%h h=%h gt=%0d ft=%0d",
                     want.status, want.fslot, want.gslot, want.fx, want.fy, want.fh,
                     want.gtot, want.ftot);
            $display("          got st=%0d fs=%0d gs=%0d ax=%h ay=%h h=%h gt=%0d ft=%0d",
                     got.status, got.fslot, got.gslot, got.fx, got.fy, got.fh,
                     got.gtot, got.ftot);
          end
        end
      end
    end
  end

  function automatic request_t font_req(int p);
    request_t r;
    r = '0;
    r.req = REQ_FONT_SEL;
    r.fid = pool_id[p];
    r.ca = pool_a[p];
    r.cb = pool_b[p];
    r.cc = pool_c[p];
    r.cd = pool_d[p];
    return r;
  endfunction

  function automatic request_t glyph_req(logic [1:0] kind, logic [15:0] key);
    request_t r;
    r = '0;
    r.req = kind;
    r.key = key;
    r.ax = 16'($urandom);
    r.ay = 16'($urandom);
    r.bh = 16'($urandom);
    return r;
  endfunction

  // Random request: mostly pooled fonts and small keys, some pure noise.
  function automatic request_t random_req();
    request_t r;
    int pick;
    logic [15:0] key;
    logic [223:0] noise;
    pick = $urandom_range(19);
    key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    if (pick < 5) begin
      r = font_req($urandom_range(POOL_N - 1));
      if ($urandom_range(4) == 0) r.fid = 16'($urandom);
    end else if (pick < 12) r = glyph_req(REQ_STORE, key);
    else if (pick < 19) r = glyph_req(REQ_LOOKUP, key);
    else begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(request_t)-1:0];
      r.req = REQ_UNKNOWN;
    end
    return r;
  endfunction

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_answers.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    apply_config(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int glim_set[7] = '{4, 256, 0, 511, 17, 9, 40};
    int flim_set[7] = '{3, 8, 1, 15, 0, 2, 5};
    int pct_send[4] = '{0, 59, 0, 28};
    int pct_recv[4] = '{0, 0, 59, 28};
    request_t r;

    glim = NGLYPH;
    flim = NFONT;
    fcount = 0;
    cur_font = NO_FONT;
    gcount = 0;
    for (int s = 0; s < NFONT; s++) begin
      fv[s] = 0;
      fage[s] = 0;
    end
    clear_table();
    for (int p = 0; p < POOL_N; p++) begin
      pool_id[p] = 16'($urandom);
      pool_a[p] = $urandom;
      pool_b[p] = $urandom;
      pool_c[p] = $urandom;
      pool_d[p] = $urandom;
    end
    // Extreme fonts at the head of the pool.
    pool_id[0] = 16'h0000;
    {pool_a[0], pool_b[0], pool_c[0], pool_d[0]} = {32'h80000000, 32'h0, 32'h7fffffff, 32'h0};
    pool_id[1] = 16'hffff;
    {pool_a[1], pool_b[1], pool_c[1], pool_d[1]} = {4{32'hffffffff}};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no current font, unknown request, extremes, hit and miss.
    pending_reqs.push_back(glyph_req(REQ_STORE, 16'h0001));
    pending_reqs.push_back(glyph_req(REQ_LOOKUP, 16'h0001));
    r = '1;
    r.req = REQ_UNKNOWN;
    pending_reqs.push_back(r);
    pending_reqs.push_back(font_req(0));
    r = glyph_req(REQ_STORE, 16'h0000);
    {r.ax, r.ay, r.bh} = {16'h8000, 16'h7fff, 16'hffff};
    pending_reqs.push_back(r);
    pending_reqs.push_back(font_req(1));
    r = glyph_req(REQ_STORE, 16'hffff);
    {r.ax, r.ay, r.bh} = {16'h7fff, 16'h8000, 16'h0000};
    pending_reqs.push_back(r);
    pending_reqs.push_back(glyph_req(REQ_LOOKUP, 16'hffff));
    pending_reqs.push_back(glyph_req(REQ_LOOKUP, 16'h1234));
    pending_reqs.push_back(font_req(0));
    pending_reqs.push_back(glyph_req(REQ_LOOKUP, 16'h0000));
    wait_drained();

    // One-entry table: the second store evicts its own font and is dropped.
    write_reg(CFG_GLYPH_LIMIT, 9'd1);
    write_reg(CFG_FONT_LIMIT, 9'd2);
    pending_reqs.push_back(font_req(2));
    pending_reqs.push_back(glyph_req(REQ_STORE, 16'h0005));
    pending_reqs.push_back(glyph_req(REQ_STORE, 16'h0006));
    pending_reqs.push_back(glyph_req(REQ_LOOKUP, 16'h0005));
    for (int p = 3; p < 6; p++) pending_reqs.push_back(font_req(p));
    wait_drained();

    // Font limit raised to fill the set, then lowered below the fonts held.
    write_reg(CFG_FONT_LIMIT, 9'd8);
    for (int p = 2; p < 8; p++) pending_reqs.push_back(font_req(p));
    wait_drained();
    write_reg(CFG_FONT_LIMIT, 9'd1);
    pending_reqs.push_back(font_req(8));
    pending_reqs.push_back(font_req(8));
    wait_drained();

    // Random phases over several register settings and idling modes.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_GLYPH_LIMIT, 9'(glim_set[ph]));
      write_reg(CFG_FONT_LIMIT, 9'(flim_set[ph]));
      send_idle_pct = pct_send[ph % 4];
      recv_idle_pct = pct_recv[ph % 4];
      for (int n = 0; n < 78; n++) pending_reqs.push_back(random_req());
      if (ph == 4) stall_arm = 1;
      wait_drained();
    end

    repeat (600) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
